FILE: rtl/slfr_pkg.sv
package slfr_pkg;

  // Fixed field widths of the frame format.
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int CFG_INDEX_W = 2;

  // Default depth of the request queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Sync pair that opens every frame.
  localparam logic [BYTE_W-1:0] SYNC_A = 8'hAB;
  localparam logic [BYTE_W-1:0] SYNC_B = 8'hBA;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY_LEN = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [WORD_W-1:0] TIMEOUT_TICKS_RST = 16'd200;
  localparam logic [WORD_W-1:0] MAX_BODY_LEN_RST = 16'd256;

  // Input item function codes.
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Result kinds.
  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Frame end status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_CHECK_ERR = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Request classes decided by the front.
  localparam logic [1:0] CLS_TICK = 2'd0;
  localparam logic [1:0] CLS_SYNC_A = 2'd1;
  localparam logic [1:0] CLS_SYNC_B = 2'd2;
  localparam logic [1:0] CLS_DATA = 2'd3;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] body_byte;
    logic [1:0]        status;
    logic [BYTE_W-1:0] src_id;
    logic [BYTE_W-1:0] dest_id;
    logic [BYTE_W-1:0] cmd_code;
    logic [WORD_W-1:0] msg_index;
    logic [WORD_W-1:0] body_length;
  } out_item_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic [1:0]        cls;
    logic [BYTE_W-1:0] data;
  } req_t;

endpackage

FILE: rtl/sync_length_lrc_frame_receiver.sv
// Frame receiver for sync-word framed, length-prefixed messages with a
// 16-bit LRC. Each input request is a received byte or one poll tick. The
// receiver hunts for the sync pair 0xAB 0xBA, reads the length, source,
// destination, command and index header, passes each body byte out as it
// arrives, and ends each frame with a report carrying the header fields and
// a status (ok, checksum error, length too long or timeout). Requests enter
// a small queue at the input and a result register at the output, so one
// request is taken every clock cycle while the output is drained; a result
// is registered at the output from the parser step that takes its request,
// paced by the single parser step per cycle. Configuration writes are always
// accepted and must only be issued while the receiver is idle. No memory
// clearing is needed after reset.
module sync_length_lrc_frame_receiver
  import slfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  logic q_valid;
  logic q_pop;
  req_t q_req;

  // Front: classifies and queues requests.
  slfr_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  // Back: frame parser, checksum and result register.
  slfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/slfr_front.sv
module slfr_front
  import slfr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     q_valid,
  output req_t     q_req,
  input  logic     q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  req_t             req_in;
  logic             push;
  logic             pop;

  // Classify the incoming request.
  always_comb begin
    req_in.data = in_item.rx_byte;
    if (in_item.func == FUNC_TICK) begin
      req_in.cls = CLS_TICK;
    end else if (in_item.rx_byte == SYNC_A) begin
      req_in.cls = CLS_SYNC_A;
    end else if (in_item.rx_byte == SYNC_B) begin
      req_in.cls = CLS_SYNC_B;
    end else begin
      req_in.cls = CLS_DATA;
    end
  end

  assign in_ready = (count != CNT_W'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_req    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= req_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/slfr_back.sv
module slfr_back
  import slfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  req_t                   q_req,
  output logic                   q_pop,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item
);

  localparam logic [3:0] PH_HUNT1  = 4'd0;
  localparam logic [3:0] PH_HUNT2  = 4'd1;
  localparam logic [3:0] PH_LEN_LO = 4'd2;
  localparam logic [3:0] PH_LEN_HI = 4'd3;
  localparam logic [3:0] PH_SRC    = 4'd4;
  localparam logic [3:0] PH_DEST   = 4'd5;
  localparam logic [3:0] PH_CMD    = 4'd6;
  localparam logic [3:0] PH_IDX_LO = 4'd7;
  localparam logic [3:0] PH_IDX_HI = 4'd8;
  localparam logic [3:0] PH_BODY   = 4'd9;
  localparam logic [3:0] PH_CHK_LO = 4'd10;
  localparam logic [3:0] PH_CHK_HI = 4'd11;

  logic [WORD_W-1:0] timeout_ticks;
  logic [WORD_W-1:0] max_body_len;

  logic [3:0]        phase;
  logic [WORD_W-1:0] body_count;
  logic [WORD_W-1:0] length_reg;
  logic [WORD_W-1:0] running_sum;
  logic [BYTE_W-1:0] src_reg;
  logic [BYTE_W-1:0] dest_reg;
  logic [BYTE_W-1:0] cmd_reg;
  logic [WORD_W-1:0] index_reg;
  logic [BYTE_W-1:0] check_low_reg;
  logic [WORD_W-1:0] timer_left;

  logic              take;
  logic              is_tick;
  logic [BYTE_W-1:0] b;
  logic [WORD_W-1:0] sum_next;
  logic [WORD_W-1:0] length_next;
  logic [WORD_W-1:0] count_next;
  logic [WORD_W-1:0] check_word;
  logic              timer_expired;
  logic              res_valid;
  out_item_t         res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_TICKS_RST;
      max_body_len  <= MAX_BODY_LEN_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TIMEOUT_TICKS) begin
        timeout_ticks <= cfg_data;
      end else if (cfg_index == REG_MAX_BODY_LEN) begin
        max_body_len <= cfg_data;
      end
    end
  end

  // A request is taken when the result register is free or drains now.
  assign q_pop = q_valid && (!out_valid || out_ready);
  assign take  = q_pop;

  assign is_tick       = (q_req.cls == CLS_TICK);
  assign b             = q_req.data;
  assign sum_next      = running_sum + WORD_W'(b);
  assign length_next   = {b, length_reg[BYTE_W-1:0]};
  assign count_next    = body_count + 1'b1;
  assign check_word    = {b, check_low_reg};
  assign timer_expired = (timer_left <= WORD_W'(1));

  // Result of the current request, built from the frame registers and the current byte.
  always_comb begin
    res_valid       = 1'b0;
    res.kind        = KIND_BODY;
    res.body_byte   = '0;
    res.status      = ST_OK;
    res.src_id      = src_reg;
    res.dest_id     = dest_reg;
    res.cmd_code    = cmd_reg;
    res.msg_index   = index_reg;
    res.body_length = length_reg;
    if (is_tick) begin
      if (phase != PH_HUNT1 && phase != PH_HUNT2 && timer_expired) begin
        res_valid  = 1'b1;
        res.kind   = KIND_REPORT;
        res.status = ST_TIMEOUT;
      end
    end else begin
      case (phase)
        PH_LEN_HI: begin
          if (length_next > max_body_len) begin
            res_valid       = 1'b1;
            res.kind        = KIND_REPORT;
            res.status      = ST_TOO_LONG;
            res.body_length = length_next;
          end
        end
        PH_BODY: begin
          res_valid     = 1'b1;
          res.body_byte = b;
        end
        PH_CHK_HI: begin
          res_valid  = 1'b1;
          res.kind   = KIND_REPORT;
          res.status = ((running_sum + check_word) == '0) ? ST_OK : ST_CHECK_ERR;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // Frame parser.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      timer_left    <= '0;
      body_count    <= '0;
      length_reg    <= '0;
      running_sum   <= '0;
      src_reg       <= '0;
      dest_reg      <= '0;
      cmd_reg       <= '0;
      index_reg     <= '0;
      check_low_reg <= '0;
    end else if (take) begin
      if (is_tick) begin
        if (phase != PH_HUNT1) begin
          if (timer_expired) begin
            phase         <= PH_HUNT1;
            timer_left    <= '0;
            body_count    <= '0;
            length_reg    <= '0;
            running_sum   <= '0;
            src_reg       <= '0;
            dest_reg      <= '0;
            cmd_reg       <= '0;
            index_reg     <= '0;
            check_low_reg <= '0;
          end else begin
            timer_left <= timer_left - 1'b1;
          end
        end
      end else begin
        case (phase)
          PH_HUNT1: begin
            if (q_req.cls == CLS_SYNC_A) begin
              phase      <= PH_HUNT2;
              timer_left <= timeout_ticks;
            end
          end
          PH_HUNT2: begin
            if (q_req.cls == CLS_SYNC_B) begin
              phase         <= PH_LEN_LO;
              body_count    <= '0;
              length_reg    <= '0;
              running_sum   <= '0;
              src_reg       <= '0;
              dest_reg      <= '0;
              cmd_reg       <= '0;
              index_reg     <= '0;
              check_low_reg <= '0;
            end else if (q_req.cls != CLS_SYNC_A) begin
              phase <= PH_HUNT1;
            end
          end
          PH_LEN_LO: begin
            running_sum <= sum_next;
            length_reg  <= WORD_W'(b);
            phase       <= PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (length_next > max_body_len) begin
              phase         <= PH_HUNT1;
              body_count    <= '0;
              length_reg    <= '0;
              running_sum   <= '0;
              src_reg       <= '0;
              dest_reg      <= '0;
              cmd_reg       <= '0;
              index_reg     <= '0;
              check_low_reg <= '0;
            end else begin
              running_sum <= sum_next;
              length_reg  <= length_next;
              phase       <= PH_SRC;
            end
          end
          PH_SRC: begin
            running_sum <= sum_next;
            src_reg     <= b;
            phase       <= PH_DEST;
          end
          PH_DEST: begin
            running_sum <= sum_next;
            dest_reg    <= b;
            phase       <= PH_CMD;
          end
          PH_CMD: begin
            running_sum <= sum_next;
            cmd_reg     <= b;
            phase       <= PH_IDX_LO;
          end
          PH_IDX_LO: begin
            running_sum <= sum_next;
            index_reg   <= WORD_W'(b);
            phase       <= PH_IDX_HI;
          end
          PH_IDX_HI: begin
            running_sum <= sum_next;
            index_reg   <= {b, index_reg[BYTE_W-1:0]};
            body_count  <= '0;
            phase       <= (length_reg == '0) ? PH_CHK_LO : PH_BODY;
          end
          PH_BODY: begin
            running_sum <= sum_next;
            body_count  <= count_next;
            if (count_next >= length_reg) begin
              phase <= PH_CHK_LO;
            end
          end
          PH_CHK_LO: begin
            check_low_reg <= b;
            phase         <= PH_CHK_HI;
          end
          PH_CHK_HI: begin
            phase         <= PH_HUNT1;
            timer_left    <= '0;
            body_count    <= '0;
            length_reg    <= '0;
            running_sum   <= '0;
            src_reg       <= '0;
            dest_reg      <= '0;
            cmd_reg       <= '0;
            index_reg     <= '0;
            check_low_reg <= '0;
          end
          default: begin
            phase <= PH_HUNT1;
          end
        endcase
      end
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_item <= res;
    end
  end

endmodule
